// ===== rtl/core/tpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfa_pkg
// shared types and constants of the tagged page frame allocator
// ----------------------------------------------------------------------------
package tpfa_pkg;

  // number of physical 4 MB frames under management
  localparam int Frames = 32;
  localparam int IdxW   = $clog2(Frames);
  localparam int CntW   = $clog2(Frames + 1);

  // fixed field widths of the transactions
  localparam int DirW   = 8;
  localparam int PageW  = 10;
  localparam int FrameW = 5;
  localparam int CountW = 6;

  // frames 0 and 1 are reserved out of reset
  localparam logic [Frames-1:0] UsedRst = {{(Frames-2){1'b0}}, 2'b11};
  localparam logic [CntW-1:0]   CountRst = CntW'(Frames - 2);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic             cmd;
    logic [DirW-1:0]  dir_id;
    logic [PageW-1:0] vaddr_page;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [FrameW-1:0] frame_index;
    logic [DirW-1:0]   entry_dir;
    logic [PageW-1:0]  entry_index;
    logic              entry_present;
    logic [FrameW-1:0] entry_frame;
    logic [CountW-1:0] free_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/tpfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpfa_ctrl
// request sequencer: takes one transaction, then commits it to the datapath
// ----------------------------------------------------------------------------
module tpfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tpfa_pkg::dp_status_t status_i,
  output tpfa_pkg::dp_cmd_t    cmd_o
);

  tpfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpfa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tpfa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tpfa_pkg::ST_EXEC;
      end
      tpfa_pkg::ST_EXEC: begin
        if (status_i.out_free) state_d = tpfa_pkg::ST_IDLE;
      end
      default: state_d = tpfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.load    = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      tpfa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      tpfa_pkg::ST_EXEC: begin
        // wait for room in the output register
        cmd_o.commit = status_i.out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/tpfa_dpath.sv =====
// ----------------------------------------------------------------------------
// tpfa_dpath
// frame bitmap, tag store, first-fit / tag match search and result register
// ----------------------------------------------------------------------------
module tpfa_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tpfa_pkg::req_t       in_data_i,
  input  tpfa_pkg::dp_cmd_t    cmd_i,
  output tpfa_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tpfa_pkg::rsp_t       out_data_o
);

  tpfa_pkg::req_t                         req_q;
  logic [tpfa_pkg::Frames-1:0]            used_q, used_d;
  logic [tpfa_pkg::Frames-1:0]            valid_q, valid_d;
  logic [tpfa_pkg::DirW-1:0]              dir_q  [tpfa_pkg::Frames];
  logic [tpfa_pkg::PageW-1:0]             page_q [tpfa_pkg::Frames];
  logic [tpfa_pkg::CntW-1:0]              count_q, count_d;
  logic                                   out_valid_q;
  tpfa_pkg::rsp_t                         out_q;

  logic [tpfa_pkg::Frames-1:0] match_vec;
  logic [tpfa_pkg::Frames-1:0] sel_vec;
  logic [tpfa_pkg::IdxW-1:0]   sel_idx;
  logic                        is_free;
  logic                        ok;

  assign is_free = (req_q.cmd == tpfa_pkg::CMD_FREE);

  // tag compare across every frame
  always_comb begin
    for (int i = 0; i < tpfa_pkg::Frames; i++) begin
      match_vec[i] = used_q[i] && valid_q[i] &&
                     (dir_q[i] == req_q.dir_id) && (page_q[i] == req_q.vaddr_page);
    end
  end

  assign sel_vec = is_free ? match_vec : ~used_q;

  // lowest set bit wins
  always_comb begin
    sel_idx = '0;
    for (int i = tpfa_pkg::Frames - 1; i >= 0; i--) begin
      if (sel_vec[i]) sel_idx = tpfa_pkg::IdxW'(i);
    end
  end

  assign ok = (|sel_vec) && (is_free || (count_q != '0));

  always_comb begin
    used_d  = used_q;
    valid_d = valid_q;
    count_d = count_q;
    if (ok) begin
      used_d[sel_idx]  = !is_free;
      valid_d[sel_idx] = !is_free;
      count_d          = is_free ? count_q + 1'b1 : count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= tpfa_pkg::UsedRst;
      valid_q     <= '0;
      count_q     <= tpfa_pkg::CountRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        used_q  <= used_d;
        valid_q <= valid_d;
        count_q <= count_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.commit && ok && !is_free) begin
      dir_q[sel_idx]  <= req_q.dir_id;
      page_q[sel_idx] <= req_q.vaddr_page;
    end
    if (cmd_i.commit) begin
      out_q.ok            <= ok;
      out_q.frame_index   <= ok ? tpfa_pkg::FrameW'(sel_idx) : '0;
      out_q.entry_dir     <= req_q.dir_id;
      out_q.entry_index   <= req_q.vaddr_page;
      out_q.entry_present <= ok && !is_free;
      out_q.entry_frame   <= (ok && !is_free) ? tpfa_pkg::FrameW'(sel_idx) : '0;
      out_q.free_count    <= tpfa_pkg::CountW'(count_d);
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// ===== rtl/core/tagged_page_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tagged_page_frame_allocator_unit
// first-fit 4 MB frame allocator with (directory, page) tags
// ----------------------------------------------------------------------------
// the sequencer takes one request and registers it, then commits the tag compare,
//   priority encode and write-back to the output register once that has room;
//   no further request is taken until then
// reset: asynchronous, frames 0 and 1 reserved, all tags invalid, 30 free;
//   no clearing pass, the sequencer leaves reset idle and takes requests at once
module tagged_page_frame_allocator_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  // request channel
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tpfa_pkg::req_t in_data_i,
  // result channel
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tpfa_pkg::rsp_t out_data_o
);

  tpfa_pkg::dp_cmd_t    dp_cmd;
  tpfa_pkg::dp_status_t dp_status;

  // sequencer: idle / execute, holds in execute while the result is stalled
  tpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // bitmap, tags, search and output register; the output register lets the
  // next request in while a finished result still waits
  tpfa_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/tpfa_checker.sv =====
// ----------------------------------------------------------------------------
// tpfa_checker
// port level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
module tpfa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tpfa_pkg::rsp_t out_data_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // one request at a time: stall right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  // count never exceeds the frame total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.free_count <= tpfa_pkg::CountW'(tpfa_pkg::Frames))
    else $error("free count out of range");

  // failed requests carry no frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |->
      out_data_o.frame_index == '0 && !out_data_o.entry_present &&
      out_data_o.entry_frame == '0)
    else $error("failed result carries a frame");

  // a present entry points at a non-reserved frame it reports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entry_present |->
      out_data_o.ok && out_data_o.entry_frame == out_data_o.frame_index &&
      out_data_o.frame_index >= tpfa_pkg::FrameW'(2))
    else $error("bad present entry");

endmodule

bind tagged_page_frame_allocator_unit tpfa_checker u_tpfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
